FILE: rtl/core/tba_pkg.sv
// shared types, constants and message table for the temperature band alarm
`timescale 1ns / 1ps
`default_nettype none

package tba_pkg;

    localparam int MESSAGE_BYTES_DEF = 5;
    localparam int SAMPLE_BITS_DEF   = 10;

    localparam int MARGIN_BITS = 10;
    localparam int PERIOD_BITS = 8;
    localparam int ADDR_BITS   = 4;
    localparam int OUT_BITS    = 8;

    localparam logic [MARGIN_BITS-1:0] OUTER_RST  = 10'd5;
    localparam logic [MARGIN_BITS-1:0] INNER_RST  = 10'd2;
    localparam logic [PERIOD_BITS-1:0] PERIOD_RST = 8'd52;

    localparam logic [1:0] REG_OUTER  = 2'd0;
    localparam logic [1:0] REG_INNER  = 2'd1;
    localparam logic [1:0] REG_PERIOD = 2'd2;

    localparam logic [1:0] BAND_NONE = 2'd0;
    localparam logic [1:0] BAND_LOW  = 2'd1;
    localparam logic [1:0] BAND_HIGH = 2'd2;
    localparam logic [1:0] BAND_IN   = 2'd3;

    localparam logic [3:0] FRAME_BITS = 4'd10;
    localparam logic [9:0] FRAME_IDLE = 10'h3FF;

    localparam logic [7:0] CH_H  = 8'h48;
    localparam logic [7:0] CH_I  = 8'h49;
    localparam logic [7:0] CH_L  = 8'h4C;
    localparam logic [7:0] CH_O  = 8'h4F;
    localparam logic [7:0] CH_N  = 8'h4E;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_BS = 8'h08;

    typedef struct packed {
        logic [MARGIN_BITS-1:0] outer_margin;
        logic [MARGIN_BITS-1:0] inner_margin;
        logic [PERIOD_BITS-1:0] bit_period;
    } t_cfg;

    function automatic logic [7:0] msg_byte(input logic [1:0] kind, input logic [2:0] idx);
        logic [7:0] b;
        b = CH_BS;
        if (idx == 3'd0) begin
            b = (kind == BAND_LOW) ? CH_L : ((kind == BAND_HIGH) ? CH_H : CH_I);
        end else if (idx == 3'd1) begin
            b = (kind == BAND_LOW) ? CH_O : ((kind == BAND_HIGH) ? CH_I : CH_N);
        end else if (idx == 3'd2) begin
            b = CH_LF;
        end
        return b;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/tba_front.sv
// input side: takes stream transfers, packs command flag and sample and holds them in a two-entry queue
`timescale 1ns / 1ps
`default_nettype none

module tba_front
    import tba_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_in_valid,
    input  wire                    i_in_sample_cmd,
    input  wire  [SAMPLE_BITS-1:0] i_in_sample,
    output logic                   o_in_ready,
    output logic                   o_valid,
    output logic [SAMPLE_BITS:0]   o_item,
    input  wire                    i_pop
);

    logic [SAMPLE_BITS:0] r_mem [2];
    logic                 r_wptr;
    logic                 r_rptr;
    logic [1:0]           r_count;
    logic [1:0]           n_count;
    logic                 push;

    assign o_in_ready = (r_count != 2'd2);
    assign push       = i_in_valid && o_in_ready;
    assign o_valid    = (r_count != 2'd0);
    assign o_item     = r_mem[r_rptr];

    always_comb begin
        n_count = r_count;
        if (push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
            if (push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
        end
    end

    // sample field is don't-care on ticks, kept anyway
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= {i_in_sample_cmd, i_in_sample};
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/tba_back.sv
// execution side: band decision, led state and 8n1 message transmitter with output register
`timescale 1ns / 1ps
`default_nettype none

module tba_back
    import tba_pkg::*;
#(
    parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
    parameter int MESSAGE_BYTES = MESSAGE_BYTES_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  t_cfg                 i_cfg,
    input  wire                  i_valid,
    input  wire  [SAMPLE_BITS:0] i_item,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output logic [OUT_BITS-1:0]  o_out_data
);

    localparam int CW = (SAMPLE_BITS > MARGIN_BITS) ? SAMPLE_BITS : MARGIN_BITS;
    localparam logic [3:0] LAST_IDX = 4'(MESSAGE_BYTES);

    logic [SAMPLE_BITS-1:0] r_ref, n_ref;
    logic                   r_red, n_red;
    logic                   r_green, n_green;
    logic [1:0]             r_band, n_band;
    logic [9:0]             r_shift, n_shift;
    logic [3:0]             r_bits, n_bits;
    logic [7:0]             r_ticks, n_ticks;
    logic [1:0]             r_kind, n_kind;
    logic [2:0]             r_idx, n_idx;
    logic                   r_send, n_send;
    logic                   r_out_valid;
    logic [OUT_BITS-1:0]    r_out_data;

    logic                   fire;
    logic                   is_sample;
    logic [SAMPLE_BITS-1:0] smp;
    logic [SAMPLE_BITS-1:0] ref_eff;
    logic [SAMPLE_BITS-1:0] diff;
    logic                   ref_above;
    logic [CW-1:0]          diff_w;
    logic [1:0]             cls;
    logic [7:0]             period;
    logic [3:0]             bits_dec;
    logic                   dropped;

    assign fire        = i_valid && (!r_out_valid || i_out_ready);
    assign o_pop       = fire;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign is_sample = i_item[SAMPLE_BITS];
    assign smp       = i_item[SAMPLE_BITS-1:0];
    assign ref_eff   = (r_ref == '0) ? smp : r_ref;
    assign ref_above = (ref_eff >= smp);
    assign diff      = ref_above ? (ref_eff - smp) : (smp - ref_eff);
    assign diff_w    = CW'(diff);
    assign period    = (i_cfg.bit_period == 8'd0) ? 8'd1 : i_cfg.bit_period;
    assign bits_dec  = (r_bits != 4'd0) ? (r_bits - 4'd1) : 4'd0;

    always_comb begin
        if (diff_w > CW'(i_cfg.outer_margin)) begin
            cls = ref_above ? BAND_LOW : BAND_HIGH;
        end else if (diff_w <= CW'(i_cfg.inner_margin)) begin
            cls = BAND_IN;
        end else begin
            cls = BAND_NONE;
        end
    end

    always_comb begin
        n_ref   = r_ref;
        n_red   = r_red;
        n_green = r_green;
        n_band  = r_band;
        n_shift = r_shift;
        n_bits  = r_bits;
        n_ticks = r_ticks;
        n_kind  = r_kind;
        n_idx   = r_idx;
        n_send  = r_send;
        dropped = 1'b0;
        if (!is_sample) begin
            if (r_send) begin
                if ({1'b0, r_ticks} + 9'd1 < {1'b0, period}) begin
                    n_ticks = r_ticks + 8'd1;
                end else begin
                    n_ticks = 8'd0;
                    n_shift = {1'b1, r_shift[9:1]};
                    n_bits  = bits_dec;
                    if (bits_dec == 4'd0) begin
                        if ({1'b0, r_idx} + 4'd1 >= LAST_IDX) begin
                            n_send  = 1'b0;
                            n_idx   = 3'd0;
                            n_shift = FRAME_IDLE;
                        end else begin
                            n_idx   = r_idx + 3'd1;
                            n_shift = {1'b1, msg_byte(r_kind, r_idx + 3'd1), 1'b0};
                            n_bits  = FRAME_BITS;
                        end
                    end
                end
            end
        end else if (r_send) begin
            dropped = 1'b1;
        end else begin
            n_ref = ref_eff;
            if (cls != BAND_NONE) begin
                n_green = (cls == BAND_LOW);
                n_red   = (cls == BAND_HIGH);
                n_band  = cls;
                n_kind  = cls;
                n_idx   = 3'd0;
                n_send  = 1'b1;
                n_shift = {1'b1, msg_byte(cls, 3'd0), 1'b0};
                n_bits  = FRAME_BITS;
                n_ticks = 8'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref       <= '0;
            r_red       <= 1'b0;
            r_green     <= 1'b0;
            r_band      <= BAND_NONE;
            r_shift     <= FRAME_IDLE;
            r_bits      <= 4'd0;
            r_ticks     <= 8'd0;
            r_kind      <= BAND_NONE;
            r_idx       <= 3'd0;
            r_send      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_ref   <= n_ref;
                r_red   <= n_red;
                r_green <= n_green;
                r_band  <= n_band;
                r_shift <= n_shift;
                r_bits  <= n_bits;
                r_ticks <= n_ticks;
                r_kind  <= n_kind;
                r_idx   <= n_idx;
                r_send  <= n_send;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // bit 0 txd, 1 red, 2 green, 4:3 band, 5 busy, 6 dropped
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_data <= {1'b0, dropped, n_send, n_band, n_green, n_red,
                           (n_send ? n_shift[0] : 1'b1)};
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/temperature_band_alarm_uart_unit.sv
// top level: register port, input queue front and transmitter back
// a result is held in a queue entry and then in the output register before it is presented
// throughput: one item per cycle while the output register is free or accepted, set by the execution stage in the back
// the two-entry queue keeps input accepting while a result waits on the output
// reset: synchronous active low; clears leds, band, reference and transmitter,
// margins return to 5 and 2, bit period to 52
`timescale 1ns / 1ps
`default_nettype none

module temperature_band_alarm_uart_unit
    import tba_pkg::*;
#(
    parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
    parameter int MESSAGE_BYTES = MESSAGE_BYTES_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire  [((SAMPLE_BITS+7)/8)*8-1:0]    s_axis_tdata,  // sample
    input  wire                                 s_axis_tuser,  // command
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    // txd, led_red, led_green, band[1:0], busy_res, dropped
    output logic [OUT_BITS-1:0]                 m_axis_tdata,
    input  wire                                 psel,
    input  wire                                 penable,
    input  wire                                 pwrite,
    input  wire  [ADDR_BITS-1:0]                paddr,
    input  wire  [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    t_cfg                 r_cfg;
    logic                 q_valid;
    logic [SAMPLE_BITS:0] q_item;
    logic                 q_pop;
    logic                 wr_en;
    logic [1:0]           reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.outer_margin <= OUTER_RST;
            r_cfg.inner_margin <= INNER_RST;
            r_cfg.bit_period   <= PERIOD_RST;
        end else if (wr_en) begin
            unique case (reg_sel)
                REG_OUTER:  r_cfg.outer_margin <= pwdata[MARGIN_BITS-1:0];
                REG_INNER:  r_cfg.inner_margin <= pwdata[MARGIN_BITS-1:0];
                REG_PERIOD: r_cfg.bit_period   <= pwdata[PERIOD_BITS-1:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_OUTER:  prdata = 32'(r_cfg.outer_margin);
            REG_INNER:  prdata = 32'(r_cfg.inner_margin);
            REG_PERIOD: prdata = 32'(r_cfg.bit_period);
            default:    prdata = 32'd0;
        endcase
    end

    tba_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (s_axis_tvalid),
        .i_in_sample_cmd (s_axis_tuser),
        .i_in_sample     (s_axis_tdata[SAMPLE_BITS-1:0]),
        .o_in_ready      (s_axis_tready),
        .o_valid         (q_valid),
        .o_item          (q_item),
        .i_pop           (q_pop)
    );

    tba_back #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .MESSAGE_BYTES (MESSAGE_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (q_valid),
        .i_item      (q_item),
        .o_pop       (q_pop),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata)
    );

endmodule

`default_nettype wire
